@@ hw/rtl/scov3d_pkg.sv @@
// Package for the splat 3D covariance core: fixed-point widths, stage payload
// types and the rounding and saturation helpers shared by the pipeline stages.
// No dependencies.
`default_nettype none

package scov3d_pkg;

    localparam int SW  = 16;   // scale, unsigned Q8.8
    localparam int QW  = 16;   // quaternion component, signed Q2.14
    localparam int PW  = 2 * QW;   // quaternion product, 28 fraction bits
    localparam int RW  = PW + 3;   // raw rotation entry before rounding
    localparam int RRW = RW - 12;  // rotation entry, 16 fraction bits
    localparam int MPW = RRW + SW + 1; // rotation times scale, 24 fraction bits
    localparam int MW  = MPW - 6;  // M entry, 18 fraction bits
    localparam int CPW = 2 * MW;   // M product, 36 fraction bits
    localparam int CSW = CPW + 2;  // sum of three products
    localparam int OW  = 36;       // covariance output
    localparam int NCOV = 6;
    localparam int NPROD = 3 * NCOV;

    localparam logic signed [RW-1:0]  R_ONE  = RW'(1) << 28;
    localparam logic signed [RW-1:0]  R_HALF = RW'(1) << 11;
    localparam logic signed [MPW-1:0] M_HALF = MPW'(1) << 5;
    localparam logic signed [CSW-1:0] C_HALF = CSW'(1) << 19;

    // Row pair (i,k) of each upper-triangle entry: xx, xy, xz, yy, yz, zz
    localparam int COV_ROW_A [NCOV] = '{0, 0, 0, 1, 1, 2};
    localparam int COV_ROW_B [NCOV] = '{0, 1, 2, 1, 2, 2};

    typedef logic [SW-1:0]          scale_t;
    typedef scale_t [2:0]           scale_vec_t;
    typedef logic signed [PW-1:0]   qprod_t;
    typedef logic signed [RW-1:0]   rraw_t;
    typedef logic signed [RRW-1:0]  rot_elem_t;
    typedef rot_elem_t [8:0]        rot_mat_t;
    typedef logic signed [MW-1:0]   m_elem_t;
    typedef m_elem_t [8:0]          m_mat_t;
    typedef logic signed [CPW-1:0]  cprod_t;
    typedef cprod_t [NPROD-1:0]     cprod_vec_t;
    typedef logic signed [CSW-1:0]  csum_t;
    typedef logic signed [OW-1:0]   cov_t;
    typedef cov_t [NCOV-1:0]        cov_vec_t;

    typedef struct packed {
        qprod_t xx;
        qprod_t yy;
        qprod_t zz;
        qprod_t xy;
        qprod_t xz;
        qprod_t yz;
        qprod_t wx;
        qprod_t wy;
        qprod_t wz;
    } qprods_t;

    typedef struct packed {
        rot_mat_t   rot;
        scale_vec_t scale;
    } rot_item_t;

    function automatic rraw_t ext_q(input qprod_t a);
        return {{(RW-PW){a[PW-1]}}, a};
    endfunction

    function automatic csum_t ext_c(input cprod_t a);
        return {{(CSW-CPW){a[CPW-1]}}, a};
    endfunction

    // round half up, drop 12 fraction bits
    function automatic rot_elem_t rot_round(input rraw_t v);
        rraw_t t;
        t = v + R_HALF;
        return t[RRW+11:12];
    endfunction

    // round half up, drop 20 fraction bits, clamp to the output range
    function automatic cov_t cov_sat(input csum_t v);
        csum_t t;
        t = v + C_HALF;
        if (t[CSW-1:OW+19] == {(CSW-OW-19){t[OW+19]}})
        begin
            return t[OW+19:20];
        end
        else if (t[CSW-1])
        begin
            return {1'b1, {(OW-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(OW-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/scov3d_if.sv @@
// Valid/ready channel interfaces for the splat covariance core: splat input
// and covariance output. Depends on no package.
`default_nettype none

interface scov3d_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        scale_x;
    logic [15:0]        scale_y;
    logic [15:0]        scale_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source (output valid, scale_x, scale_y, scale_z,
                    output quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink (input valid, scale_x, scale_y, scale_z,
                  input quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface scov3d_out_if;
    logic               valid;
    logic               ready;
    logic signed [35:0] cov_xx;
    logic signed [35:0] cov_xy;
    logic signed [35:0] cov_xz;
    logic signed [35:0] cov_yy;
    logic signed [35:0] cov_yz;
    logic signed [35:0] cov_zz;

    modport source (output valid, cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz,
                    input ready);
    modport sink (input valid, cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/scov3d_rot.sv @@
// Stages 1-2: quaternion products, then the rounded rotation matrix.
// Depends on scov3d_pkg and scov3d_in_if.
`default_nettype none

module scov3d_rot (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    scov3d_in_if.sink                 splat,
    output logic                      rot_valid,
    input  wire logic                 rot_ready,
    output scov3d_pkg::rot_item_t     rot_item
);

    logic                   s1_valid_reg;
    scov3d_pkg::qprods_t    s1_prod_reg;
    scov3d_pkg::qprods_t    s1_prod_next;
    scov3d_pkg::scale_vec_t s1_scale_reg;
    logic                   s1_ready;

    logic                   s2_valid_reg;
    scov3d_pkg::rot_item_t  s2_item_reg;
    scov3d_pkg::rot_item_t  s2_item_next;
    logic                   s2_ready;

    scov3d_pkg::rraw_t      xx, yy, zz, xy, xz, yz, wx, wy, wz;

    assign s2_ready    = !s2_valid_reg || rot_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign splat.ready = s1_ready;

    always_comb
    begin
        s1_prod_next.xx = splat.quat_x * splat.quat_x;
        s1_prod_next.yy = splat.quat_y * splat.quat_y;
        s1_prod_next.zz = splat.quat_z * splat.quat_z;
        s1_prod_next.xy = splat.quat_x * splat.quat_y;
        s1_prod_next.xz = splat.quat_x * splat.quat_z;
        s1_prod_next.yz = splat.quat_y * splat.quat_z;
        s1_prod_next.wx = splat.quat_w * splat.quat_x;
        s1_prod_next.wy = splat.quat_w * splat.quat_y;
        s1_prod_next.wz = splat.quat_w * splat.quat_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= splat.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (splat.valid && s1_ready)
        begin
            s1_prod_reg  <= s1_prod_next;
            s1_scale_reg <= {splat.scale_z, splat.scale_y, splat.scale_x};
        end
    end

    always_comb
    begin
        xx = scov3d_pkg::ext_q(s1_prod_reg.xx);
        yy = scov3d_pkg::ext_q(s1_prod_reg.yy);
        zz = scov3d_pkg::ext_q(s1_prod_reg.zz);
        xy = scov3d_pkg::ext_q(s1_prod_reg.xy);
        xz = scov3d_pkg::ext_q(s1_prod_reg.xz);
        yz = scov3d_pkg::ext_q(s1_prod_reg.yz);
        wx = scov3d_pkg::ext_q(s1_prod_reg.wx);
        wy = scov3d_pkg::ext_q(s1_prod_reg.wy);
        wz = scov3d_pkg::ext_q(s1_prod_reg.wz);

        s2_item_next.rot[0] = scov3d_pkg::rot_round(scov3d_pkg::R_ONE - ((yy + zz) <<< 1));
        s2_item_next.rot[1] = scov3d_pkg::rot_round((xy - wz) <<< 1);
        s2_item_next.rot[2] = scov3d_pkg::rot_round((xz + wy) <<< 1);
        s2_item_next.rot[3] = scov3d_pkg::rot_round((xy + wz) <<< 1);
        s2_item_next.rot[4] = scov3d_pkg::rot_round(scov3d_pkg::R_ONE - ((xx + zz) <<< 1));
        s2_item_next.rot[5] = scov3d_pkg::rot_round((yz - wx) <<< 1);
        s2_item_next.rot[6] = scov3d_pkg::rot_round((xz - wy) <<< 1);
        s2_item_next.rot[7] = scov3d_pkg::rot_round((yz + wx) <<< 1);
        s2_item_next.rot[8] = scov3d_pkg::rot_round(scov3d_pkg::R_ONE - ((xx + yy) <<< 1));
        s2_item_next.scale  = s1_scale_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    assign rot_valid = s2_valid_reg;
    assign rot_item  = s2_item_reg;

endmodule

`default_nettype wire

@@ hw/rtl/scov3d_scale.sv @@
// Stage 3: M = R * diag(s), rounded to 18 fraction bits.
// Depends on scov3d_pkg.
`default_nettype none

module scov3d_scale (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  rot_valid,
    output logic                       rot_ready,
    input  wire scov3d_pkg::rot_item_t rot_item,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output scov3d_pkg::m_mat_t         m_mat
);

    logic                     s3_valid_reg;
    scov3d_pkg::m_mat_t       s3_mat_reg;
    scov3d_pkg::m_mat_t       s3_mat_next;
    logic                     s3_ready;
    logic signed [scov3d_pkg::MPW-1:0] prod [9];

    assign s3_ready  = !s3_valid_reg || m_ready;
    assign rot_ready = s3_ready;

    always_comb
    begin
        for (int n = 0; n < 9; n++)
        begin
            prod[n] = $signed(rot_item.rot[n]) * $signed({1'b0, rot_item.scale[n % 3]});
            prod[n] = prod[n] + scov3d_pkg::M_HALF;
            s3_mat_next[n] = prod[n][scov3d_pkg::MPW-1:6];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= rot_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rot_valid && s3_ready)
        begin
            s3_mat_reg <= s3_mat_next;
        end
    end

    assign m_valid = s3_valid_reg;
    assign m_mat   = s3_mat_reg;

endmodule

`default_nettype wire

@@ hw/rtl/scov3d_cov.sv @@
// Stages 4-5: row products of M, then three-term sums rounded and saturated
// into the output register. Depends on scov3d_pkg and scov3d_out_if.
`default_nettype none

module scov3d_cov (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               m_valid,
    output logic                    m_ready,
    input  wire scov3d_pkg::m_mat_t m_mat,
    scov3d_out_if.source            cov
);

    logic                       s4_valid_reg;
    scov3d_pkg::cprod_vec_t     s4_prod_reg;
    scov3d_pkg::cprod_vec_t     s4_prod_next;
    logic                       s4_ready;

    logic                       s5_valid_reg;
    scov3d_pkg::cov_vec_t       s5_cov_reg;
    scov3d_pkg::cov_vec_t       s5_cov_next;
    logic                       s5_ready;

    assign s5_ready = !s5_valid_reg || cov.ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign m_ready  = s4_ready;

    always_comb
    begin
        for (int e = 0; e < scov3d_pkg::NCOV; e++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                s4_prod_next[3*e+j] = $signed(m_mat[3*scov3d_pkg::COV_ROW_A[e]+j])
                                    * $signed(m_mat[3*scov3d_pkg::COV_ROW_B[e]+j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (s4_ready)
        begin
            s4_valid_reg <= m_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_valid && s4_ready)
        begin
            s4_prod_reg <= s4_prod_next;
        end
    end

    always_comb
    begin
        for (int e = 0; e < scov3d_pkg::NCOV; e++)
        begin
            s5_cov_next[e] = scov3d_pkg::cov_sat(scov3d_pkg::ext_c(s4_prod_reg[3*e])
                                               + scov3d_pkg::ext_c(s4_prod_reg[3*e+1])
                                               + scov3d_pkg::ext_c(s4_prod_reg[3*e+2]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (s5_ready)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_valid_reg && s5_ready)
        begin
            s5_cov_reg <= s5_cov_next;
        end
    end

    assign cov.valid  = s5_valid_reg;
    assign cov.cov_xx = s5_cov_reg[0];
    assign cov.cov_xy = s5_cov_reg[1];
    assign cov.cov_xz = s5_cov_reg[2];
    assign cov.cov_yy = s5_cov_reg[3];
    assign cov.cov_yz = s5_cov_reg[4];
    assign cov.cov_zz = s5_cov_reg[5];

endmodule

`default_nettype wire

@@ hw/rtl/splat_covariance_3d_core.sv @@
// Splat 3D covariance core: scales and quaternion in, six covariance entries out.
// Input transfer to result valid passes the five-register pipeline (products, rotation,
// scaling, row products, sums); one splat per cycle sustained while the output is ready.
// Each stage holds under backpressure and accepts when empty or draining.
// Reset clears the stage valid bits only; payload registers are not reset.
// Depends on scov3d_pkg, scov3d_if, scov3d_rot, scov3d_scale, scov3d_cov.
`default_nettype none

module splat_covariance_3d_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    scov3d_in_if.sink     splat,
    scov3d_out_if.source  cov
);

    logic                   rot_valid;
    logic                   rot_ready;
    scov3d_pkg::rot_item_t  rot_item;
    logic                   m_valid;
    logic                   m_ready;
    scov3d_pkg::m_mat_t     m_mat;

    scov3d_rot u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .splat     (splat),
        .rot_valid (rot_valid),
        .rot_ready (rot_ready),
        .rot_item  (rot_item)
    );

    scov3d_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .rot_valid (rot_valid),
        .rot_ready (rot_ready),
        .rot_item  (rot_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_mat     (m_mat)
    );

    scov3d_cov u_cov (
        .clk     (clk),
        .rst_n   (rst_n),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_mat   (m_mat),
        .cov     (cov)
    );

endmodule

`default_nettype wire

@@ hw/rtl/scov3d_checker.sv @@
// Port-level assertions for splat_covariance_3d_core, attached by bind.
// Depends on the top level's channel ports only.
`default_nettype none

module scov3d_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         in_valid,
    input wire logic         in_ready,
    input wire logic         out_valid,
    input wire logic         out_ready,
    input wire logic [215:0] out_data,
    input wire logic         xx_sign,
    input wire logic         yy_sign,
    input wire logic         zz_sign
);

    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_xfer && !out_xfer)
        begin
            inflight_next = inflight_reg + 3'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 3'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // hold result while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed under backpressure");

    a_diag_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !xx_sign && !yy_sign && !zz_sign)
        else $error("negative diagonal covariance");

    a_inflight_max: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd5)
        else $error("more splats in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 3'd0)
        else $error("result without a pending input transfer");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind splat_covariance_3d_core scov3d_checker u_scov3d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (splat.valid),
    .in_ready  (splat.ready),
    .out_valid (cov.valid),
    .out_ready (cov.ready),
    .out_data  ({cov.cov_xx, cov.cov_xy, cov.cov_xz, cov.cov_yy, cov.cov_yz, cov.cov_zz}),
    .xx_sign   (cov.cov_xx[35]),
    .yy_sign   (cov.cov_yy[35]),
    .zz_sign   (cov.cov_zz[35])
);

`default_nettype wire
